### hdl/energy_peak_tempo_estimator_assert.svh
// assertion macros used by the tempo estimator checker
`ifndef ENERGY_PEAK_TEMPO_ESTIMATOR_ASSERT_SVH
`define ENERGY_PEAK_TEMPO_ESTIMATOR_ASSERT_SVH

// same-cycle implication, held off during reset
`define EPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define EPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked through reset as well
`define EPT_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ept_pkg.sv
// shared types and constants of the energy peak tempo estimator
package ept_pkg;

    localparam int MAX_WINDOW  = 2048;
    localparam int INDEX_BITS  = 24;
    localparam int SAMPLE_BITS = 16;

    localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
    localparam int SQ_W       = 2 * SAMPLE_BITS - 1;
    localparam int ENERGY_W   = SQ_W + $clog2(MAX_WINDOW) + 1;
    localparam int SR_W       = 18;
    localparam int TEMPO_W    = 16;
    localparam int PEAKS_W    = 24;
    localparam int PROD_W     = SR_W + INDEX_BITS;
    localparam int NUM_W      = PROD_W + 10;
    localparam int DEN_W      = WIN_W + INDEX_BITS;
    localparam int DSH_W      = DEN_W + TEMPO_W - 1;
    localparam int STEP_W     = $clog2(TEMPO_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE   = 2'd2;

    localparam logic [SR_W-1:0]  RST_SAMPLE_RATE = 18'd44100;
    localparam logic [WIN_W-1:0] RST_WINDOW      = 12'd441;

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};
    localparam logic [TEMPO_W-1:0]    TEMPO_MAX = {TEMPO_W{1'b1}};

    typedef struct packed {
        logic [SR_W-1:0]  sample_rate;
        logic [WIN_W-1:0] window_length;
        logic             stereo_mode;
    } t_cfg;

    typedef struct packed {
        logic [SQ_W-1:0] square;
        logic            track_end;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        S_RUN,
        S_MUL,
        S_SCALE,
        S_CHK,
        S_DIV
    } t_back_state;

endpackage

### hdl/ept_front.sv
// front end: accepts samples, mixes to mono (or takes the left sample in mono mode), squares and tags the track end
module ept_front (
    input  logic           i_rst_n,
    input  ept_pkg::t_cfg  i_cfg,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [31:0]    i_s_axis_tdata,   // left_sample, right_sample
    input  logic [0:0]     i_s_axis_tuser,   // track_end
    input  ept_pkg::t_q_status i_q_status,
    output logic           o_push,
    output ept_pkg::t_item o_item
);
    import ept_pkg::*;

    logic signed [SAMPLE_BITS-1:0] w_left;
    logic signed [SAMPLE_BITS-1:0] w_right;
    logic signed [SAMPLE_BITS:0]   w_sum;
    logic signed [SAMPLE_BITS-1:0] w_mono;
    logic signed [2*SAMPLE_BITS-1:0] w_prod;

    assign w_left  = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_right = i_s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_sum   = {w_left[SAMPLE_BITS-1], w_left} + {w_right[SAMPLE_BITS-1], w_right};
    // floor halving of the stereo sum
    assign w_mono  = i_cfg.stereo_mode ? w_sum[SAMPLE_BITS:1] : w_left;
    assign w_prod  = w_mono * w_mono;

    assign o_s_axis_tready  = i_rst_n && !i_q_status.full;
    assign o_push           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_item.square    = w_prod[SQ_W-1:0];
    assign o_item.track_end = i_s_axis_tuser[0];

endmodule

### hdl/ept_queue.sv
// short queue between the front end and the back end
module ept_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ept_pkg::t_item     i_item,
    input  logic               i_pop,
    output ept_pkg::t_item     o_item,
    output ept_pkg::t_q_status o_status
);
    import ept_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W:0]   r_wr_ptr;
    logic [QPTR_W:0]   r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[QPTR_W-1:0]] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    assign o_item         = r_mem[r_rd_ptr[QPTR_W-1:0]];
    assign o_status.empty = (r_wr_ptr == r_rd_ptr);
    assign o_status.full  = (r_wr_ptr[QPTR_W-1:0] == r_rd_ptr[QPTR_W-1:0])
                            && (r_wr_ptr[QPTR_W] != r_rd_ptr[QPTR_W]);

endmodule

### hdl/ept_back.sv
// back end: window energy, peak tracking, tempo division and result register
module ept_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ept_pkg::t_cfg      i_cfg,
    input  ept_pkg::t_item     i_item,
    input  ept_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [39:0]        o_m_axis_tdata,   // tempo_sixteenths, peaks_seen
    output logic [1:0]         o_m_axis_tuser    // beat_found, tempo_clipped
);
    import ept_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [ENERGY_W-1:0]   r_energy;
    logic [WIN_W-1:0]      r_cnt;
    logic [ENERGY_W-1:0]   r_pend;
    logic                  r_pend_valid;
    logic [ENERGY_W-1:0]   r_prev;
    logic [ENERGY_W-1:0]   r_prev_prev;
    logic [INDEX_BITS-1:0] r_windows;
    logic [INDEX_BITS-1:0] r_first;
    logic [INDEX_BITS-1:0] r_last;
    logic [INDEX_BITS-1:0] r_peaks;

    logic [INDEX_BITS-1:0] r_pm1;
    logic [INDEX_BITS-1:0] r_diff;
    logic [INDEX_BITS-1:0] r_res_peaks;
    logic [PROD_W-1:0]     r_prod;
    logic [DEN_W-1:0]      r_den;
    logic [NUM_W-1:0]      r_rem;
    logic [DSH_W-1:0]      r_dsh;
    logic [TEMPO_W-1:0]    r_q;
    logic [STEP_W-1:0]     r_step;

    logic                  r_o_valid;
    logic [TEMPO_W-1:0]    r_o_tempo;
    logic [PEAKS_W-1:0]    r_o_peaks;
    logic                  r_o_found;
    logic                  r_o_clip;

    logic [WIN_W-1:0]      w_win;
    logic                  w_peak;
    logic [INDEX_BITS-1:0] n_peaks;
    logic [INDEX_BITS-1:0] n_first;
    logic [INDEX_BITS-1:0] n_last;
    logic [INDEX_BITS-1:0] n_windows;
    logic [ENERGY_W-1:0]   n_prev;
    logic [ENERGY_W-1:0]   n_prev_prev;
    logic [ENERGY_W-1:0]   w_energy_sum;
    logic [WIN_W-1:0]      w_cnt_inc;
    logic                  w_close;
    logic                  w_few_peaks;
    logic                  w_same_index;
    logic                  w_start_div;
    logic                  w_clip_big;
    logic                  w_sub_ok;
    logic                  w_div_done;
    logic                  w_out_take;

    // effective window length
    always_comb begin
        if (i_cfg.window_length == '0) begin
            w_win = WIN_W'(1);
        end else if (i_cfg.window_length > WIN_W'(MAX_WINDOW)) begin
            w_win = WIN_W'(MAX_WINDOW);
        end else begin
            w_win = i_cfg.window_length;
        end
    end

    // commit of the pending window
    always_comb begin
        w_peak = r_pend_valid && (r_windows >= INDEX_BITS'(2))
                 && (r_prev > r_prev_prev) && (r_prev > r_pend);
        n_peaks     = r_peaks;
        n_first     = r_first;
        n_last      = r_last;
        n_windows   = r_windows;
        n_prev      = r_prev;
        n_prev_prev = r_prev_prev;
        if (w_peak) begin
            if (r_peaks == '0) begin
                n_first = r_windows - 1'b1;
            end
            n_last = r_windows - 1'b1;
            if (r_peaks != INDEX_MAX) begin
                n_peaks = r_peaks + 1'b1;
            end
        end
        if (r_pend_valid) begin
            n_prev_prev = r_prev;
            n_prev      = r_pend;
            if (r_windows != INDEX_MAX) begin
                n_windows = r_windows + 1'b1;
            end
        end
    end

    assign w_energy_sum = r_energy + ENERGY_W'(i_item.square);
    assign w_cnt_inc    = r_cnt + 1'b1;
    assign w_close      = (w_cnt_inc >= w_win);
    assign w_few_peaks  = (n_peaks < INDEX_BITS'(2));
    assign w_same_index = (n_last <= n_first);
    assign w_clip_big   = (r_rem >= {r_den, {TEMPO_W{1'b0}}});
    assign w_sub_ok     = (r_rem >= NUM_W'(r_dsh));
    assign w_out_take   = r_o_valid && i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN: begin
                if (w_start_div) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:   n_state = S_SCALE;
            S_SCALE: n_state = S_CHK;
            S_CHK: begin
                n_state = w_clip_big ? S_RUN : S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop       = 1'b0;
        w_start_div = 1'b0;
        w_div_done  = 1'b0;
        unique case (r_state)
            S_RUN: begin
                o_pop       = !i_q_status.empty && !(i_item.track_end && r_o_valid);
                w_start_div = o_pop && i_item.track_end && !w_few_peaks && !w_same_index;
            end
            S_DIV: begin
                w_div_done = (r_step == '0);
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_energy     <= '0;
            r_cnt        <= '0;
            r_pend       <= '0;
            r_pend_valid <= 1'b0;
            r_prev       <= '0;
            r_prev_prev  <= '0;
            r_windows    <= '0;
            r_first      <= '0;
            r_last       <= '0;
            r_peaks      <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_take) begin
                r_o_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_item.track_end) begin
                    r_energy     <= '0;
                    r_cnt        <= '0;
                    r_pend       <= '0;
                    r_pend_valid <= 1'b0;
                    r_prev       <= '0;
                    r_prev_prev  <= '0;
                    r_windows    <= '0;
                    r_first      <= '0;
                    r_last       <= '0;
                    r_peaks      <= '0;
                    if (w_few_peaks || w_same_index) begin
                        r_o_valid <= 1'b1;
                    end
                end else begin
                    r_prev      <= n_prev;
                    r_prev_prev <= n_prev_prev;
                    r_windows   <= n_windows;
                    r_first     <= n_first;
                    r_last      <= n_last;
                    r_peaks     <= n_peaks;
                    if (w_close) begin
                        r_pend       <= w_energy_sum;
                        r_pend_valid <= 1'b1;
                        r_energy     <= '0;
                        r_cnt        <= '0;
                    end else begin
                        r_pend_valid <= 1'b0;
                        r_energy     <= w_energy_sum;
                        r_cnt        <= w_cnt_inc;
                    end
                end
            end
            if ((r_state == S_CHK && w_clip_big) || w_div_done) begin
                r_o_valid <= 1'b1;
            end
        end
    end

    // divider and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.track_end) begin
            r_pm1       <= n_peaks - 1'b1;
            r_diff      <= n_last - n_first;
            r_res_peaks <= n_peaks;
            r_o_peaks   <= PEAKS_W'(n_peaks);
            r_o_found   <= !w_few_peaks;
            r_o_clip    <= !w_few_peaks && w_same_index;
            r_o_tempo   <= w_few_peaks ? '0 : TEMPO_MAX;
        end
        unique case (r_state)
            S_MUL: begin
                r_prod <= PROD_W'(i_cfg.sample_rate) * PROD_W'(r_pm1);
                r_den  <= DEN_W'(w_win) * DEN_W'(r_diff);
            end
            S_SCALE: begin
                // times 960
                r_rem <= (NUM_W'(r_prod) << 10) - (NUM_W'(r_prod) << 6);
            end
            S_CHK: begin
                r_dsh  <= {r_den, {(TEMPO_W-1){1'b0}}};
                r_step <= STEP_W'(TEMPO_W - 1);
                r_q    <= '0;
                if (w_clip_big) begin
                    r_o_tempo <= TEMPO_MAX;
                    r_o_clip  <= 1'b1;
                    r_o_found <= 1'b1;
                    r_o_peaks <= PEAKS_W'(r_res_peaks);
                end
            end
            S_DIV: begin
                if (w_sub_ok) begin
                    r_rem <= r_rem - NUM_W'(r_dsh);
                end
                r_q    <= {r_q[TEMPO_W-2:0], w_sub_ok};
                r_dsh  <= r_dsh >> 1;
                r_step <= r_step - 1'b1;
                if (w_div_done) begin
                    r_o_tempo <= {r_q[TEMPO_W-2:0], w_sub_ok};
                    r_o_clip  <= 1'b0;
                    r_o_found <= 1'b1;
                    r_o_peaks <= PEAKS_W'(r_res_peaks);
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_peaks, r_o_tempo};
    assign o_m_axis_tuser  = {r_o_clip, r_o_found};

endmodule

### hdl/energy_peak_tempo_estimator.sv
// top level of the energy peak tempo estimator
// Takes one stereo sample per clock (a four-entry queue decouples the sample front end from
// the energy and peak back end) and gives one tempo result on the sample that carries
// track_end. The back end adds one squared sample to the window energy per cycle in S_RUN
// while the queue is not empty; at a track end with two or more peaks at distinct indexes
// it works out the tempo (multiply, scale, a range check that saturates too large a tempo,
// else one-bit-per-step restoring division) while the next track fills the queue until it
// stalls input. A track end with fewer than two peaks, or equal peak indexes, is reported
// at once. The result waits in an output register; the back end keeps consuming samples,
// stalling only at the next track end until it is taken. There is no reset sweep.
module energy_peak_tempo_estimator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // left_sample, right_sample
    input  logic [0:0]  i_s_axis_tuser,   // track_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // tempo_sixteenths, peaks_seen
    output logic [1:0]  o_m_axis_tuser,   // beat_found, tempo_clipped
    input  logic        i_cfg_wr_en,
    input  logic [ept_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [ept_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ept_pkg::*;

    t_cfg      r_cfg;
    t_item     w_push_item;
    t_item     w_head_item;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_rate   <= RST_SAMPLE_RATE;
            r_cfg.window_length <= RST_WINDOW;
            r_cfg.stereo_mode   <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_SAMPLE_RATE:   r_cfg.sample_rate   <= i_cfg_data[SR_W-1:0];
                CFG_WINDOW_LENGTH: r_cfg.window_length <= i_cfg_data[WIN_W-1:0];
                CFG_STEREO_MODE:   r_cfg.stereo_mode   <= i_cfg_data[0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    ept_front u_front (
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_status      (w_q_status),
        .o_push          (w_push),
        .o_item          (w_push_item)
    );

    ept_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_q_status)
    );

    ept_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item          (w_head_item),
        .i_q_status      (w_q_status),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

### hdl/ept_checker.sv
// port-level checks of the tempo estimator and their bind
`include "energy_peak_tempo_estimator_assert.svh"

module ept_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    `EPT_ASSERT_ALWAYS(a_no_result_after_reset, !i_rst_n, !o_m_axis_tvalid, "result valid after reset")

    `EPT_ASSERT_NEXT(a_result_held, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result dropped while stalled")

    `EPT_ASSERT_NOW(a_no_beat_zero, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata[15:0] == 16'd0 && !o_m_axis_tuser[1], "tempo without beat")

    `EPT_ASSERT_NOW(a_clip_saturates, o_m_axis_tvalid && o_m_axis_tuser[1], o_m_axis_tdata[15:0] == 16'hFFFF && o_m_axis_tuser[0], "clipped tempo not saturated")

endmodule

bind energy_peak_tempo_estimator ept_checker u_ept_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

### test/tb_energy_peak_tempo_estimator.sv
// testbench of the energy peak tempo estimator: stereo sample streams against a tempo predictor
typedef struct packed {
    logic [23:0] peaks;
    logic [15:0] tempo;
    logic        clipped;
    logic        found;
} tempo_result_t;

class tempo_scoreboard;
    bit [17:0]     rate;
    bit [11:0]     win_reg;
    bit            stereo;
    bit [41:0]     acc_energy;
    int unsigned   fill;
    bit [41:0]     closed_energy;
    bit            closed_held;
    bit [41:0]     e_last;
    bit [41:0]     e_before;
    bit [23:0]     n_windows;
    bit [23:0]     first_peak;
    bit [23:0]     last_peak;
    bit [23:0]     n_peaks;
    tempo_result_t pending_tempos[$];
    int            errors;
    int            n_checked;
    int            n_samples;

    function new();
        rate      = 18'd44100;
        win_reg   = 12'd441;
        stereo    = 1'b1;
        errors    = 0;
        n_checked = 0;
        n_samples = 0;
        clear_track();
    endfunction

    function void clear_track();
        acc_energy    = '0;
        fill          = 0;
        closed_energy = '0;
        closed_held   = 1'b0;
        e_last        = '0;
        e_before      = '0;
        n_windows     = '0;
        first_peak    = '0;
        last_peak     = '0;
        n_peaks       = '0;
    endfunction

    function void write_reg(logic [ept_pkg::CFG_IDX_W-1:0] idx, logic [17:0] val);
        case (idx)
            ept_pkg::CFG_SAMPLE_RATE:   rate = val;
            ept_pkg::CFG_WINDOW_LENGTH: win_reg = val[11:0];
            ept_pkg::CFG_STEREO_MODE:   stereo = val[0];
            default: ;
        endcase
    endfunction

    function int unsigned eff_window();
        if (win_reg == 0) return 1;
        if (win_reg > ept_pkg::MAX_WINDOW) return ept_pkg::MAX_WINDOW;
        return win_reg;
    endfunction

    function void note_sample(logic signed [15:0] l, logic signed [15:0] r, logic te);
        longint            m;
        longint unsigned   w;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   q;
        tempo_result_t     res;
        w = eff_window();
        n_samples++;
        // the window closed on the previous sample is committed now
        if (closed_held) begin
            if (n_windows >= 2 && e_last > e_before && e_last > closed_energy) begin
                if (n_peaks == 0) first_peak = n_windows - 1;
                last_peak = n_windows - 1;
                if (n_peaks != ept_pkg::INDEX_MAX) n_peaks++;
            end
            e_before = e_last;
            e_last   = closed_energy;
            if (n_windows != ept_pkg::INDEX_MAX) n_windows++;
            closed_held = 1'b0;
        end
        if (stereo) m = (longint'(l) + longint'(r)) >>> 1;
        else m = longint'(l);
        acc_energy += 42'(m * m);
        fill++;
        if (fill >= w) begin
            closed_energy = acc_energy;
            closed_held   = 1'b1;
            acc_energy    = '0;
            fill          = 0;
        end
        if (!te) return;
        res.tempo   = '0;
        res.found   = 1'b0;
        res.clipped = 1'b0;
        res.peaks   = n_peaks;
        if (n_peaks >= 2) begin
            res.found = 1'b1;
            if (last_peak <= first_peak) begin
                res.tempo   = ept_pkg::TEMPO_MAX;
                res.clipped = 1'b1;
            end else begin
                num = 64'd960 * rate * (n_peaks - 1);
                den = w * (last_peak - first_peak);
                q   = num / den;
                if (q > 65535) begin
                    res.tempo   = ept_pkg::TEMPO_MAX;
                    res.clipped = 1'b1;
                end else begin
                    res.tempo = q[15:0];
                end
            end
        end
        pending_tempos = {pending_tempos, res};
        clear_track();
    endfunction

    function void check_result(logic [39:0] data, logic [1:0] user);
        tempo_result_t exp_r;
        if (pending_tempos.size() == 0) begin
            $display("%0t: result with none expected, tdata %h tuser %b", $time, data, user);
            errors++;
            return;
        end
        exp_r = pending_tempos.pop_front();
        n_checked++;
        if (data[15:0] !== exp_r.tempo) begin
            $display("%0t: tempo expected %0d, actual %0d", $time, exp_r.tempo, data[15:0]);
            errors++;
        end
        if (data[39:16] !== exp_r.peaks) begin
            $display("%0t: peaks expected %0d, actual %0d", $time, exp_r.peaks, data[39:16]);
            errors++;
        end
        if (user[0] !== exp_r.found) begin
            $display("%0t: beat_found expected %b, actual %b", $time, exp_r.found, user[0]);
            errors++;
        end
        if (user[1] !== exp_r.clipped) begin
            $display("%0t: clipped expected %b, actual %b", $time, exp_r.clipped, user[1]);
            errors++;
        end
    endfunction
endclass

module tb_energy_peak_tempo_estimator;
    import ept_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int MIN_TRACKS   = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [31:0]           i_s_axis_tdata = '0;  // left_sample, right_sample
    logic [0:0]            i_s_axis_tuser = '0;  // track_end
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [39:0]           o_m_axis_tdata;       // tempo_sixteenths, peaks_seen
    logic [1:0]            o_m_axis_tuser;       // beat_found, tempo_clipped
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tempo_scoreboard sb;
    bit              idle_on = 1'b1;
    int unsigned     cycles = 0;
    int              n_items = 0;
    int              n_tracks = 0;
    int              n_settings = 0;

    energy_peak_tempo_estimator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_energy_peak_tempo_estimator NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    // result sink with stall bursts
    initial begin : sink
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_m_axis_tready <= 1'b0;
                hold--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                hold = $urandom_range(0, 2);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [15:0] pick_sample(int amp);
        if (amp >= 32768) return 16'($urandom);
        return 16'($urandom_range(0, 2 * amp) - amp);
    endfunction

    task automatic send_sample(logic [15:0] l, logic [15:0] r, logic te);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r, l};
        i_s_axis_tuser  <= te;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_sample(l, r, te);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [17:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(logic [17:0] sr, logic [11:0] w, logic st);
        write_reg(CFG_SAMPLE_RATE, sr);
        write_reg(CFG_WINDOW_LENGTH, 18'(w));
        write_reg(CFG_STEREO_MODE, 18'(st));
        @(negedge i_clk) i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // stop input, collect every result, then let the back end settle
    task automatic finish_phase();
        @(negedge i_clk) i_s_axis_tvalid <= 1'b0;
        while (sb.pending_tempos.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // noise, beat-like or near-silent content
    task automatic play_track(int len, logic closed);
        int          pattern;
        int          period;
        int          offset;
        int          loud;
        int          amp;
        int          w;
        logic [15:0] l;
        logic [15:0] r;
        pattern = $urandom_range(0, 3);
        period  = $urandom_range(2, 4);
        offset  = $urandom_range(0, 3);
        loud    = ($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(4000, 32767);
        w       = sb.eff_window();
        for (int i = 0; i < len; i++) begin
            case (pattern)
                0: begin
                    l = 16'($urandom);
                    r = 16'($urandom);
                end
                3: begin
                    l = pick_sample($urandom_range(0, 3));
                    r = pick_sample($urandom_range(0, 3));
                end
                default: begin
                    amp = ((i / w + offset) % period == 0) ? loud : $urandom_range(0, 200);
                    l = pick_sample(amp);
                    r = l ^ 16'($urandom_range(0, 255));
                end
            endcase
            send_sample(l, r, closed && (i == len - 1));
        end
        n_items += len;
        if (closed) n_tracks++;
    endtask

    task automatic run_phase(int budget, bit open_end);
        int n;
        int w;
        int len;
        n = 0;
        w = sb.eff_window();
        while (n < budget) begin
            if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 3);
            else len = w * $urandom_range(3, 14) + $urandom_range(0, w - 1);
            play_track(len, 1'b1);
            n += len;
        end
        if (open_end) play_track($urandom_range(1, 2 * w + 2), 1'b0);
        finish_phase();
    endtask

    initial begin : stimulus
        int          p;
        logic [17:0] sr;
        logic [11:0] w;
        logic        st;
        sb = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // reset settings: tracks of one or two samples, no window ever closes
        send_sample(16'h8000, 16'h8000, 1'b1);
        send_sample(16'h7fff, 16'h7fff, 1'b1);
        send_sample(16'hffff, 16'h0000, 1'b0);
        send_sample(16'h0000, 16'hffff, 1'b1);
        finish_phase();

        // mono, one-sample windows, two peaks far beyond the output range
        set_config(18'd192000, 12'd1, 1'b0);
        for (int k = 0; k < 7; k++)
            send_sample((k % 2) ? 16'd10 : 16'd0, 16'($urandom), k == 6);
        finish_phase();

        // zero rate and zero window length, stereo rounding toward minus infinity
        set_config(18'd0, 12'd0, 1'b1);
        send_sample(16'h7fff, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h8000, 1'b0);
        send_sample(16'h0001, 16'h0000, 1'b0);
        send_sample(16'h8000, 16'h8000, 1'b0);
        send_sample(16'h0000, 16'h0000, 1'b0);
        send_sample(16'h0000, 16'h0000, 1'b1);
        finish_phase();

        // window raised past the maximum mid-track, second peak committed at the track end
        set_config(18'd8000, 12'd1, 1'b0);
        send_sample(16'h0000, 16'($urandom), 1'b0);
        send_sample(16'h7fff, 16'($urandom), 1'b0);
        send_sample(16'h0000, 16'($urandom), 1'b0);
        send_sample(16'h8000, 16'($urandom), 1'b0);
        send_sample(16'h0000, 16'($urandom), 1'b0);
        finish_phase();
        set_config(18'd8000, 12'd4095, 1'b0);
        send_sample(pick_sample(3), 16'($urandom), 1'b1);
        finish_phase();

        p = 0;
        while (p < 6 || n_items < RANDOM_ITEMS || n_tracks < MIN_TRACKS) begin
            case (p)
                0: begin sr = 18'd0;      w = 12'd3; st = 1'b1; end
                1: begin sr = 18'h3ffff;  w = 12'd0; st = 1'b0; end
                2: begin sr = 18'd8000;   w = 12'd2; st = 1'b1; end
                3: begin sr = 18'd192000; w = 12'd1; st = 1'b0; end
                4: begin sr = 18'd300;    w = 12'd6; st = 1'b1; end
                default: begin
                    case ($urandom_range(0, 2))
                        0: sr = 18'($urandom_range(1, 2000));
                        1: sr = 18'($urandom_range(8000, 192000));
                        default: sr = 18'($urandom);
                    endcase
                    w  = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(9, 24))
                                                     : 12'($urandom_range(1, 8));
                    st = 1'($urandom_range(0, 1));
                end
            endcase
            set_config(sr, w, st);
            run_phase($urandom_range(100, 220), $urandom_range(0, 2) == 0);
            p++;
        end

        // closing stretch at full rate on both sides
        idle_on = 1'b0;
        set_config(18'($urandom_range(100, 4000)), 12'($urandom_range(2, 6)),
                   1'($urandom_range(0, 1)));
        run_phase(120, 1'b0);

        $display("%0d samples, %0d tempo results, %0d register settings",
                 sb.n_samples, sb.n_checked, n_settings);
        $display("%0d mismatches", sb.errors);
        if (sb.errors == 0 && sb.pending_tempos.size() == 0)
            $display("tb_energy_peak_tempo_estimator OK");
        else
            $display("tb_energy_peak_tempo_estimator NOT OK");
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/ept_pkg.sv
hdl/ept_front.sv
hdl/ept_queue.sv
hdl/ept_back.sv
hdl/energy_peak_tempo_estimator.sv
hdl/ept_checker.sv
test/tb_energy_peak_tempo_estimator.sv
